FILE: rtl/u8dsc_pkg.sv
// ----------------------------------------------------------------------------
// u8dsc_pkg
// Shared widths, constants, burst descriptor and shaping-range test for the
// UTF-8 decoder with script classification.
// ----------------------------------------------------------------------------
package u8dsc_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int SEQ_W       = 2;
    // replacement count in one burst: up to four words
    localparam int REP_W       = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // One decoded byte's worth of output words: rep_cnt replacement words,
    // then optionally one decoded code point.
    typedef struct packed {
        logic [REP_W-1:0] rep_cnt;
        logic             has_cp;
        logic [CP_W-1:0]  cp;
        logic             sh;
        logic             shaping_old;
        logic             str_end;
    } t_burst;

    // Hebrew and Arabic blocks, including the Arabic presentation forms
    function automatic logic in_shaping_range(input logic [CP_W-1:0] cp);
        return (cp inside {[21'h000590 : 21'h0006FF]}) ||
               (cp inside {[21'h000750 : 21'h00077F]}) ||
               (cp inside {[21'h0008A0 : 21'h0008FF]}) ||
               (cp inside {[21'h00FB50 : 21'h00FDFF]}) ||
               (cp inside {[21'h00FE70 : 21'h00FEFF]});
    endfunction

endpackage

FILE: rtl/u8dsc_if.sv
// ----------------------------------------------------------------------------
// u8dsc interfaces
// Valid/ready channels for the byte stream in and the code point words out.
// ----------------------------------------------------------------------------
interface u8dsc_in_if;
    logic                         valid;
    logic                         ready;
    logic [u8dsc_pkg::BYTE_W-1:0] text_byte;
    logic                         string_final;

    modport source (output valid, output text_byte, output string_final, input ready);
    modport sink   (input valid, input text_byte, input string_final, output ready);
endinterface

interface u8dsc_out_if;
    logic                       valid;
    logic                       ready;
    logic [u8dsc_pkg::CP_W-1:0] code_point;
    logic                       is_replacement;
    logic                       needs_shaping;
    logic                       string_needs_shaping;
    logic                       burst_last;
    logic                       string_last;

    modport source (output valid, output code_point, output is_replacement,
                    output needs_shaping, output string_needs_shaping,
                    output burst_last, output string_last, input ready);
    modport sink   (input valid, input code_point, input is_replacement,
                    input needs_shaping, input string_needs_shaping,
                    input burst_last, input string_last, output ready);
endinterface

FILE: rtl/u8dsc_front.sv
// ----------------------------------------------------------------------------
// u8dsc_front
// Byte decoder: tracks the multi-byte sequence, classifies each byte and
// posts a burst descriptor per byte that yields any output word.
// ----------------------------------------------------------------------------
module u8dsc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8dsc_in_if.sink          i_byte,
    output logic              o_push,
    output u8dsc_pkg::t_burst o_burst,
    input  logic              i_room
);
    import u8dsc_pkg::*;

    logic [CP_W-1:0]  r_pc, n_pc;
    logic [SEQ_W-1:0] r_bse, n_bse;
    logic [SEQ_W-1:0] r_ct, n_ct;
    logic             r_shaping, n_shaping;

    logic             accept;
    logic [REP_W-1:0] rep;
    logic             has_cp;
    logic [CP_W-1:0]  cp_v;
    logic             sh;

    assign i_byte.ready = i_room;
    assign accept       = i_byte.valid & i_room;

    // decode of the offered byte against the current sequence
    always_comb begin
        logic [BYTE_W-1:0] b;
        logic              fin;
        logic              lead_go;
        logic [CP_W-1:0]   pc_ext;
        b       = i_byte.text_byte;
        fin     = i_byte.string_final;
        lead_go = 1'b0;
        pc_ext  = {r_pc[CP_W-7:0], b[5:0]};
        n_pc    = r_pc;
        n_bse   = r_bse;
        n_ct    = r_ct;
        rep     = '0;
        has_cp  = 1'b0;
        cp_v    = '0;

        if (r_bse != '0) begin
            if (b[7:6] == 2'b10) begin
                n_pc  = pc_ext;
                n_bse = r_bse - SEQ_W'(1);
                n_ct  = r_ct + SEQ_W'(1);
                if (n_bse == '0) begin
                    has_cp = 1'b1;
                    cp_v   = pc_ext;
                    n_pc   = '0;
                    n_ct   = '0;
                end else if (fin) begin
                    // truncated at string end
                    rep = {1'b0, n_ct} + REP_W'(1);
                end
            end else begin
                // broken sequence: flush, then retry byte as a lead
                rep     = {1'b0, r_ct} + REP_W'(1);
                lead_go = 1'b1;
                n_pc    = '0;
                n_bse   = '0;
                n_ct    = '0;
            end
        end else begin
            lead_go = 1'b1;
        end

        if (lead_go) begin
            if (!b[7]) begin
                has_cp = 1'b1;
                cp_v   = CP_W'(b);
            end else if (b[7:5] == 3'b110) begin
                if (fin) rep = rep + REP_W'(1);
                else begin
                    n_pc  = CP_W'(b[4:0]);
                    n_bse = SEQ_W'(1);
                    n_ct  = '0;
                end
            end else if (b[7:4] == 4'b1110) begin
                if (fin) rep = rep + REP_W'(1);
                else begin
                    n_pc  = CP_W'(b[3:0]);
                    n_bse = SEQ_W'(2);
                    n_ct  = '0;
                end
            end else if (b[7:3] == 5'b11110) begin
                if (fin) rep = rep + REP_W'(1);
                else begin
                    n_pc  = CP_W'(b[2:0]);
                    n_bse = SEQ_W'(3);
                    n_ct  = '0;
                end
            end else begin
                // stray continuation or invalid lead
                rep = rep + REP_W'(1);
            end
        end

        sh        = has_cp & in_shaping_range(cp_v);
        n_shaping = r_shaping | sh;

        if (fin) begin
            n_pc      = '0;
            n_bse     = '0;
            n_ct      = '0;
            n_shaping = 1'b0;
        end
    end

    // descriptor towards the queue
    assign o_push              = accept & ((rep != '0) | has_cp);
    assign o_burst.rep_cnt     = rep;
    assign o_burst.has_cp      = has_cp;
    assign o_burst.cp          = cp_v;
    assign o_burst.sh          = sh;
    assign o_burst.shaping_old = r_shaping;
    assign o_burst.str_end     = i_byte.string_final;

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_bse     <= '0;
            r_ct      <= '0;
            r_shaping <= 1'b0;
        end else if (accept) begin
            r_pc      <= n_pc;
            r_bse     <= n_bse;
            r_ct      <= n_ct;
            r_shaping <= n_shaping;
        end
    end

endmodule

FILE: rtl/u8dsc_fifo.sv
// ----------------------------------------------------------------------------
// u8dsc_fifo
// Short flop queue of burst descriptors between the decoder and the
// word emitter.
// ----------------------------------------------------------------------------
module u8dsc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8dsc_pkg::t_burst i_data,
    output logic              o_room,
    input  logic              i_pop,
    output logic              o_avail,
    output u8dsc_pkg::t_burst o_data
);
    import u8dsc_pkg::*;

    t_burst                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  do_push, do_pop;

    assign o_room  = (r_cnt != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & o_room;
    assign do_pop  = i_pop & o_avail;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + FIFO_PTR_W'(1);
            if (do_pop)
                r_rd <= (r_rd == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + FIFO_PTR_W'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + FIFO_CNT_W'(1);
            else if (!do_push && do_pop) r_cnt <= r_cnt - FIFO_CNT_W'(1);
        end
    end

endmodule

FILE: rtl/u8dsc_back.sv
// ----------------------------------------------------------------------------
// u8dsc_back
// Word emitter: expands each burst descriptor into its replacement words and
// code point word, one word per cycle while the receiver is ready, into a registered output.
// ----------------------------------------------------------------------------
module u8dsc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  u8dsc_pkg::t_burst i_burst,
    output logic              o_pop,
    u8dsc_out_if.source       o_cp
);
    import u8dsc_pkg::*;

    t_burst           r_cur;
    logic             r_busy;
    logic [REP_W-1:0] r_rem;
    logic             r_oval;

    logic             adv, fire, last, is_cp, w_sh;

    assign adv   = !r_oval | o_cp.ready;
    assign fire  = r_busy & adv;
    assign last  = (r_rem == REP_W'(1));
    assign is_cp = last & r_cur.has_cp;
    assign w_sh  = is_cp & r_cur.sh;
    assign o_pop = i_avail & (!r_busy | (fire & last));

    // burst generator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rem  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_rem  <= i_burst.rep_cnt + REP_W'(i_burst.has_cp);
        end else if (fire) begin
            r_rem  <= r_rem - REP_W'(1);
            if (last) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= i_burst;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_oval <= 1'b0;
        else if (adv) r_oval <= fire;
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_cp.code_point           <= is_cp ? r_cur.cp : REPL_CP;
            o_cp.is_replacement       <= !is_cp;
            o_cp.needs_shaping        <= w_sh;
            o_cp.string_needs_shaping <= r_cur.shaping_old | w_sh;
            o_cp.burst_last           <= last;
            o_cp.string_last          <= last & r_cur.str_end;
        end
    end

    assign o_cp.valid = r_oval;

endmodule

FILE: rtl/utf8_decode_script_classify.sv
// Path: an accepted byte's descriptor is written to the descriptor queue, popped
// into the emitter's burst register, and its words leave through the output register.
// Throughput: one byte per cycle in while the 4-deep descriptor queue has room,
// one word per cycle out while the receiver is ready; bursts hold up to four words.
// Reset: synchronous active-low i_rst_n clears sequence state, queue and output valid.
// ----------------------------------------------------------------------------
// utf8_decode_script_classify
// UTF-8 decoder with Arabic/Hebrew flagging: decoder front, descriptor queue,
// word emitter back.
// ----------------------------------------------------------------------------
module utf8_decode_script_classify (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8dsc_in_if.sink     i_byte,
    u8dsc_out_if.source  o_cp
);
    import u8dsc_pkg::*;

    logic   push, room, pop, avail;
    t_burst front_burst, head_burst;

    u8dsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .o_push  (push),
        .o_burst (front_burst),
        .i_room  (room)
    );

    u8dsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_burst),
        .o_room  (room),
        .i_pop   (pop),
        .o_avail (avail),
        .o_data  (head_burst)
    );

    u8dsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_burst (head_burst),
        .o_pop   (pop),
        .o_cp    (o_cp)
    );

endmodule

FILE: rtl/u8dsc_checker.sv
// ----------------------------------------------------------------------------
// u8dsc_checker
// Port-level checks on the decoded word stream, bound to the top level.
// ----------------------------------------------------------------------------
module u8dsc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [u8dsc_pkg::CP_W-1:0] i_code_point,
    input logic                       i_is_replacement,
    input logic                       i_needs_shaping,
    input logic                       i_string_needs_shaping,
    input logic                       i_burst_last,
    input logic                       i_string_last
);
    import u8dsc_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_code_point) && $stable(i_burst_last))
        else $error("stalled output word changed");

    // string end closes a burst
    a_strlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_string_last |-> i_burst_last)
        else $error("string_last without burst_last");

    // error words carry the replacement character and never shape
    a_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_replacement |-> i_code_point == REPL_CP && !i_needs_shaping)
        else $error("bad replacement word");

    // running shaping flag covers the current word
    a_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_needs_shaping |-> i_string_needs_shaping)
        else $error("string shaping flag missing");

    // no word straight out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

endmodule

bind utf8_decode_script_classify u8dsc_checker u_chk (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_valid                (o_cp.valid),
    .i_ready                (o_cp.ready),
    .i_code_point           (o_cp.code_point),
    .i_is_replacement       (o_cp.is_replacement),
    .i_needs_shaping        (o_cp.needs_shaping),
    .i_string_needs_shaping (o_cp.string_needs_shaping),
    .i_burst_last           (o_cp.burst_last),
    .i_string_last          (o_cp.string_last)
);

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_decode_script_classify. Byte strings go in with
// random gaps and the code point words coming out are checked against a
// behavioural decoder. The strings used are well-formed UTF-8 with Hebrew and
// Arabic content, truncated sequences, stray bytes and the error paths.
// ----------------------------------------------------------------------------
module tb;
    import u8dsc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 85;

    // one output word as the bench sees it
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_repl;
        logic            shaping;
        logic            string_shaping;
        logic            burst_last;
        logic            string_last;
    } t_cp_word;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    // ------------------------------------------------------------------------
    // Decoder model plus store of the words still awaited from the block
    // ------------------------------------------------------------------------
    class utf8_checker;
        logic [CP_W-1:0] partial;
        logic [1:0]      still_needed;
        logic [1:0]      conts_taken;
        logic            shaping_seen;
        t_cp_word        burst[$];
        t_cp_word        awaited_words[$];
        int unsigned     mismatches;

        function new();
            clear_seq();
            shaping_seen = 1'b0;
            mismatches   = 0;
        endfunction

        function void clear_seq();
            partial      = '0;
            still_needed = '0;
            conts_taken  = '0;
        endfunction

        // Hebrew, Arabic and the Arabic presentation forms
        function logic in_arabic_hebrew(logic [CP_W-1:0] cp);
            return (cp >= 21'h000590 && cp <= 21'h0006FF) ||
                   (cp >= 21'h000750 && cp <= 21'h00077F) ||
                   (cp >= 21'h0008A0 && cp <= 21'h0008FF) ||
                   (cp >= 21'h00FB50 && cp <= 21'h00FDFF) ||
                   (cp >= 21'h00FE70 && cp <= 21'h00FEFF);
        endfunction

        function void push_word(logic [CP_W-1:0] cp, logic repl);
            t_cp_word w;
            if (burst.size() >= 4) return;
            w.code_point     = cp;
            w.is_repl        = repl;
            w.shaping        = in_arabic_hebrew(cp);
            shaping_seen     = shaping_seen | w.shaping;
            w.string_shaping = shaping_seen;
            w.burst_last     = 1'b0;
            w.string_last    = 1'b0;
            burst.push_back(w);
        endfunction

        // broken sequence: one replacement for the lead and one per continuation
        function void flush_broken();
            for (int i = 0; i <= int'(conts_taken) && i < 4; i++)
                push_word(REPL_CP, 1'b1);
            clear_seq();
        endfunction

        function void take_lead(logic [BYTE_W-1:0] b, logic fin);
            logic [1:0]      need;
            logic [CP_W-1:0] bits;
            if (b[7] == 1'b0) begin
                push_word({14'd0, b[6:0]}, 1'b0);
                return;
            end else if (b[7:5] == 3'b110) begin
                need = 2'd1;
                bits = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                need = 2'd2;
                bits = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                need = 2'd3;
                bits = {18'd0, b[2:0]};
            end else begin
                push_word(REPL_CP, 1'b1);
                return;
            end
            // multi-byte lead as the last byte of the string
            if (fin) begin
                push_word(REPL_CP, 1'b1);
                return;
            end
            partial      = bits;
            still_needed = need;
            conts_taken  = 2'd0;
        endfunction

        // accepted input byte: predict the burst of words it causes
        function void note_byte(logic [BYTE_W-1:0] b, logic fin);
            t_cp_word w;
            burst.delete();
            if (still_needed != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    partial      = {partial[CP_W-7:0], b[5:0]};
                    still_needed = still_needed - 2'd1;
                    conts_taken  = conts_taken + 2'd1;
                    if (still_needed == 2'd0) begin
                        push_word(partial, 1'b0);
                        clear_seq();
                    end else if (fin) begin
                        flush_broken();
                    end
                end else begin
                    flush_broken();
                    take_lead(b, fin);
                end
            end else begin
                take_lead(b, fin);
            end
            if (burst.size() > 0) begin
                w = burst.pop_back();
                w.burst_last  = 1'b1;
                w.string_last = fin;
                burst.push_back(w);
            end
            if (fin) begin
                clear_seq();
                shaping_seen = 1'b0;
            end
            foreach (burst[i]) awaited_words.push_back(burst[i]);
        endfunction

        function void report(string what, t_cp_word e, t_cp_word g);
            mismatches++;
            if (mismatches <= 10)
                $display({"%s: exp cp=%06h repl=%b sh=%b ssh=%b bl=%b sl=%b",
                          " | got cp=%06h repl=%b sh=%b ssh=%b bl=%b sl=%b"},
                         what, e.code_point, e.is_repl, e.shaping, e.string_shaping,
                         e.burst_last, e.string_last, g.code_point, g.is_repl, g.shaping,
                         g.string_shaping, g.burst_last, g.string_last);
        endfunction

        // accepted output word: compare with the oldest awaited one
        function void check_word(t_cp_word got);
            t_cp_word exp_w;
            if (awaited_words.size() == 0) begin
                report("unexpected word", '0, got);
                return;
            end
            exp_w = awaited_words.pop_front();
            if (exp_w !== got) report("word mismatch", exp_w, got);
        endfunction

        function int pending_count();
            return awaited_words.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    u8dsc_in_if  byte_if ();
    u8dsc_out_if cp_if ();

    utf8_checker chk;
    t_byte_q     text_q;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          phase_items;
    int          quiet_cycles;

    utf8_decode_script_classify dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_if),
        .o_cp    (cp_if)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: random stalls on the word channel
    initial begin
        cp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            cp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // monitor: bytes taken, words checked, watchdog on quiet cycles
    always @(posedge clk) begin : monitor
        t_cp_word got;
        logic     took;
        if (rst_n) begin
            took = 1'b0;
            if (byte_if.valid && byte_if.ready) begin
                chk.note_byte(byte_if.text_byte, byte_if.string_final);
                took = 1'b1;
            end
            if (cp_if.valid && cp_if.ready) begin
                got.code_point     = cp_if.code_point;
                got.is_repl        = cp_if.is_replacement;
                got.shaping        = cp_if.needs_shaping;
                got.string_shaping = cp_if.string_needs_shaping;
                got.burst_last     = cp_if.burst_last;
                got.string_last    = cp_if.string_last;
                chk.check_word(got);
                took = 1'b1;
            end
            quiet_cycles = took ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // one byte, with a random gap ahead of it; returns at its acceptance
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid        <= 1'b1;
        byte_if.text_byte    <= b;
        byte_if.string_final <= fin;
        @(posedge clk);
        while (!byte_if.ready) @(posedge clk);
    endtask

    task automatic send_string(input t_byte_q s);
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
        phase_items += s.size();
    endtask

    // sender holds off until every awaited word has come
    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (chk.pending_count() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic void push_utf8(input logic [CP_W-1:0] cp, input int len);
        case (len)
            1: text_q.push_back({1'b0, cp[6:0]});
            2: begin
                text_q.push_back({3'b110, cp[10:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                text_q.push_back({4'b1110, cp[15:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                text_q.push_back({5'b11110, cp[20:18]});
                text_q.push_back({2'b10, cp[17:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // code point in or just around one of the shaping ranges
    function automatic logic [CP_W-1:0] shaping_cp();
        logic [CP_W-1:0] lo, hi;
        case ($urandom_range(0, 4))
            0: begin lo = 21'h000590; hi = 21'h0006FF; end
            1: begin lo = 21'h000750; hi = 21'h00077F; end
            2: begin lo = 21'h0008A0; hi = 21'h0008FF; end
            3: begin lo = 21'h00FB50; hi = 21'h00FDFF; end
            default: begin lo = 21'h00FE70; hi = 21'h00FEFF; end
        endcase
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            2: return lo - 21'd1;
            3: return hi + 21'd1;
            default: return CP_W'($urandom_range(lo, hi));
        endcase
    endfunction

    // random string: mostly well-formed, some noise and cut sequences
    task automatic build_string();
        int sel;
        int len;
        logic [CP_W-1:0] cp;
        text_q.delete();
        repeat ($urandom_range(1, 6)) begin
            sel = $urandom_range(0, 99);
            if (sel < 28) begin
                push_utf8(CP_W'($urandom_range(0, 127)), 1);
            end else if (sel < 55) begin
                cp = shaping_cp();
                push_utf8(cp, (cp < 21'h000800) ? 2 : 3);
            end else if (sel < 65) begin
                push_utf8(CP_W'($urandom_range(0, 21'h0007FF)), 2);
            end else if (sel < 76) begin
                push_utf8(CP_W'($urandom_range(0, 21'h00FFFF)), 3);
            end else if (sel < 86) begin
                push_utf8(CP_W'($urandom_range(0, 21'h1FFFFF)), 4);
            end else if (sel < 91) begin
                text_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end else if (sel < 96) begin
                len = $urandom_range(2, 4);
                push_utf8(CP_W'($urandom_range(0, 21'h1FFFFF)), len);
                repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
            end else begin
                text_q.push_back({2'b10, 6'($urandom_range(0, 63))});
            end
        end
    endtask

    // main sequence
    initial begin
        chk            = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        phase_items    = 0;
        quiet_cycles   = 0;
        rst_n                <= 1'b0;
        byte_if.valid        <= 1'b0;
        byte_if.text_byte    <= '0;
        byte_if.string_final <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings
        send_string('{8'h00, 8'h7F});                      // ASCII extremes
        send_string('{8'hD7, 8'h90, 8'hEF, 8'hBB, 8'hBF}); // Hebrew, then FEFF
        send_string('{8'hF7, 8'hBF, 8'hBF, 8'hBF});        // widest code point
        send_string('{8'h80});                             // stray continuation
        send_string('{8'hFF});                             // bad lead
        send_string('{8'hF0, 8'h90, 8'h80, 8'h41});        // bad continuation
        send_string('{8'hE2, 8'h82});                      // cut at string end
        send_string('{8'hC3});                             // lead as final byte
        send_string('{8'hEF, 8'hBF, 8'hBD});               // genuine U+FFFD
        send_string('{8'hE2, 8'hC3, 8'hA9});               // lead breaks a lead
        wait_drained();

        // random strings over the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
                default: begin src_idle_pct = 17; sink_stall_pct = 17; end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                build_string();
                send_string(text_q);
            end
            wait_drained();
        end

        if (chk.mismatches == 0 && chk.pending_count() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/u8dsc_pkg.sv
rtl/u8dsc_if.sv
rtl/u8dsc_front.sv
rtl/u8dsc_fifo.sv
rtl/u8dsc_back.sv
rtl/utf8_decode_script_classify.sv
rtl/u8dsc_checker.sv
verif/tb.sv
